### rtl/rb_pkg.sv
package rb_pkg;

  // Build defaults
  localparam int unsigned DEFAULT_MAX_ENTRIES = 256;

  // Fixed field widths
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IN_DATA_W  = 72;  // tag, number, info
  localparam int unsigned OUT_DATA_W = 80;  // 77 result bits, zero padded

  // Operation codes carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 2'd0,
    FN_MARK   = 2'd1,
    FN_ASK    = 2'd2,
    FN_RETIRE = 2'd3
  } func_e;

  // Per-item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

### rtl/reorder_buffer.sv
// Sequence: an accepted input word passes the read and done states; the done state loads
//   the result register. A stalled master side holds the result register and delays the
//   next input word, accepted only in the idle state once the previous result is loaded.
//   Every operation goes through the synchronous read of the entry memories (payload, ready flag).
// Reset: head, tail, occupancy, head-ready flag cleared and size set to MAX_ENTRIES capped
//   at 256; entry memories are not cleared, no clearing pass. A size write empties the
//   buffer.
module reorder_buffer #(
  parameter int unsigned MAX_ENTRIES = rb_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // size register write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rb_pkg::CFG_W-1:0]       cfg_data_i,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] entry_tag, [39:8] instr_number, [71:40] instr_info
  input  logic [rb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [rb_pkg::FUNC_W-1:0]      s_axis_tuser,
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] accepted, [8:1] alloc_index, [9] tag_ready, [10] retired,
  // [42:11] retired_number, [74:43] retired_info, [75] has_space, [76] head_ready
  output logic [rb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned SZ_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW    = (SZ_W > rb_pkg::CFG_W) ? SZ_W : rb_pkg::CFG_W;
  localparam int unsigned TW    = ((SZ_W > rb_pkg::TAG_W) ? SZ_W : rb_pkg::TAG_W) + 1;
  localparam int unsigned SIZE_RST = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int unsigned DW    = 2 * rb_pkg::WORD_W;

  // Control state
  rb_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [SZ_W-1:0]  occ_q, occ_d;
  logic [SZ_W-1:0]  size_q, size_d;
  logic             hr_q, hr_d;          // head entry valid and ready
  logic             m_valid_q;

  // Latched item and per-item flags
  rb_pkg::func_e             func_q;
  logic [rb_pkg::TAG_W-1:0]  tag_q;
  logic [rb_pkg::WORD_W-1:0] num_q;
  logic [rb_pkg::WORD_W-1:0] info_q;
  logic                      ok_q, ok_d;
  logic                      acc_q, acc_d;
  logic [IDX_W-1:0]          idx_q;
  logic [rb_pkg::OUT_DATA_W-1:0] m_data_q, res_word;

  // Memories
  logic [DW-1:0]    data_mem [MAX_ENTRIES];
  logic             rdy_mem  [MAX_ENTRIES];
  logic [DW-1:0]    data_rd_q;
  logic             rdy_rd_q;
  logic             dmem_we, rmem_we, rmem_wdata;
  logic [IDX_W-1:0] rmem_waddr, rmem_raddr;

  // Handshake and sequencing strobes
  logic in_acc, cfg_acc, out_load;

  // Address arithmetic
  logic [SZ_W-1:0]  head_p1, tail_p1;
  logic [IDX_W-1:0] head_nxt, tail_nxt;
  logic [TW-1:0]    tag_x, head_x, size_x, occ_x, tag_dist;
  logic             tag_ok;
  logic [CW-1:0]    cfg_x;
  logic [SZ_W-1:0]  cfg_size;
  logic             has_space, hr_new;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // Pointer advance with wrap at the size in use
  assign head_p1  = SZ_W'(head_q) + SZ_W'(1);
  assign tail_p1  = SZ_W'(tail_q) + SZ_W'(1);
  assign head_nxt = (head_p1 >= size_q) ? '0 : head_p1[IDX_W-1:0];
  assign tail_nxt = (tail_p1 >= size_q) ? '0 : tail_p1[IDX_W-1:0];

  // Tag is valid when it lies in the occupied window starting at head
  assign tag_x    = TW'(tag_q);
  assign head_x   = TW'(head_q);
  assign size_x   = TW'(size_q);
  assign occ_x    = TW'(occ_q);
  assign tag_dist = (tag_x >= head_x) ? (tag_x - head_x) : (tag_x + size_x - head_x);
  assign tag_ok   = (tag_x < size_x) && (tag_dist < occ_x);

  // Size clamp for register writes
  always_comb begin
    cfg_x = CW'(cfg_data_i);
    if (cfg_x == '0) begin
      cfg_size = SZ_W'(1);
    end else if (cfg_x > CW'(MAX_ENTRIES)) begin
      cfg_size = SZ_W'(MAX_ENTRIES);
    end else begin
      cfg_size = cfg_x[SZ_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rb_pkg::ST_IDLE: if (in_acc) state_d = rb_pkg::ST_READ;
      rb_pkg::ST_READ: state_d = rb_pkg::ST_DONE;
      rb_pkg::ST_DONE: if (out_load) state_d = rb_pkg::ST_IDLE;
      default:         state_d = rb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      rb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cfg_ready_o   = 1'b1;
      end
      rb_pkg::ST_READ: ;
      rb_pkg::ST_DONE: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // Memory port control
  assign dmem_we    = (state_q == rb_pkg::ST_READ) && (func_q == rb_pkg::FN_ALLOC) &&
                      (occ_q < size_q);
  assign rmem_we    = dmem_we ||
                      ((state_q == rb_pkg::ST_READ) && (func_q == rb_pkg::FN_MARK) && tag_ok);
  assign rmem_wdata = (func_q == rb_pkg::FN_MARK);
  assign rmem_waddr = (func_q == rb_pkg::FN_MARK) ? tag_x[IDX_W-1:0] : tail_q;
  assign rmem_raddr = (func_q == rb_pkg::FN_ASK) ? tag_x[IDX_W-1:0] : head_nxt;

  // Payload memory: written at tail, read at head in the read cycle only
  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      data_mem[tail_q] <= {info_q, num_q};
    end
    if (state_q == rb_pkg::ST_READ) begin
      data_rd_q <= data_mem[head_q];
    end
  end

  // Ready flag memory; read data held until the result is loaded
  always_ff @(posedge clk_i) begin
    if (rmem_we) begin
      rdy_mem[rmem_waddr] <= rmem_wdata;
    end
    if (state_q == rb_pkg::ST_READ) begin
      rdy_rd_q <= rdy_mem[rmem_raddr];
    end
  end

  // Pointer and count updates in the read cycle, head flag on a mark in the read cycle and when the result is loaded
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    size_d = size_q;
    hr_d   = hr_q;
    ok_d   = ok_q;
    acc_d  = acc_q;
    if (state_q == rb_pkg::ST_READ) begin
      ok_d  = 1'b0;
      acc_d = 1'b0;
      case (func_q)
        rb_pkg::FN_ALLOC: begin
          if (occ_q < size_q) begin
            acc_d  = 1'b1;
            tail_d = tail_nxt;
            occ_d  = occ_q + SZ_W'(1);
          end
        end
        rb_pkg::FN_MARK: begin
          if (tag_ok && (tag_x == head_x)) hr_d = 1'b1;
        end
        rb_pkg::FN_ASK: ok_d = tag_ok;
        default: begin
          if (hr_q) begin
            ok_d   = 1'b1;
            head_d = head_nxt;
            occ_d  = occ_q - SZ_W'(1);
          end
        end
      endcase
    end
    if (out_load) begin
      hr_d = hr_new;
    end
    if (cfg_acc) begin
      size_d = cfg_size;
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
      hr_d   = 1'b0;
    end
  end

  // Result word
  assign has_space = occ_q < size_q;
  assign hr_new    = ((func_q == rb_pkg::FN_RETIRE) && ok_q) ?
                     ((occ_q != '0) && rdy_rd_q) : hr_q;

  always_comb begin
    res_word = '0;
    res_word[0]     = acc_q;
    res_word[8:1]   = acc_q ? rb_pkg::TAG_W'(idx_q) : '0;
    res_word[9]     = (func_q == rb_pkg::FN_ASK) && ok_q && rdy_rd_q;
    res_word[10]    = (func_q == rb_pkg::FN_RETIRE) && ok_q;
    if ((func_q == rb_pkg::FN_RETIRE) && ok_q) begin
      res_word[42:11] = data_rd_q[rb_pkg::WORD_W-1:0];
      res_word[74:43] = data_rd_q[DW-1:rb_pkg::WORD_W];
    end
    res_word[75]    = has_space;
    res_word[76]    = hr_new;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rb_pkg::ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      size_q    <= SZ_W'(SIZE_RST);
      hr_q      <= 1'b0;
      ok_q      <= 1'b0;
      acc_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      size_q  <= size_d;
      hr_q    <= hr_d;
      ok_q    <= ok_d;
      acc_q   <= acc_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= rb_pkg::func_e'(s_axis_tuser);
      tag_q  <= s_axis_tdata[7:0];
      num_q  <= s_axis_tdata[39:8];
      info_q <= s_axis_tdata[71:40];
    end
    if (state_q == rb_pkg::ST_READ) begin
      idx_q <= tail_q;
    end
    if (out_load) begin
      m_data_q <= res_word;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= size_q)
    else $error("occupancy above size in use");

  // head flag is set by a mark in the read cycle and refreshed when the result is loaded
  a_hr_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hr_q && (state_q != rb_pkg::ST_DONE)) |-> (occ_q != '0))
    else $error("head ready flag set on empty buffer");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dmem_we && !cfg_acc) |=> (occ_q == $past(occ_q) + SZ_W'(1)))
    else $error("allocate did not grow occupancy");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == rb_pkg::ST_READ) ##1 (state_q == rb_pkg::ST_DONE))
    else $error("item sequencing broken");

endmodule
